>>> rtl/core/sfr_pkg.sv
// Shared constants, types and register codes for the stream find-and-replace block.
`timescale 1ns / 1ps

package sfr_pkg;

    // Longest pattern the window compares against (1 to 8)
    localparam int PATTERN_MAX = 8;

    // Window and replacement storage, in bytes
    localparam int WIN_DEPTH   = 8;
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int COUNT_W     = 4;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 8'd0,
        CFG_PATTERN_LENGTH     = 8'd1,
        CFG_REPLACEMENT_BYTES  = 8'd2,
        CFG_REPLACEMENT_LENGTH = 8'd3
    } cfg_index_t;

    typedef logic [WIN_DEPTH-1:0][7:0] byte_vec_t;

    // One unit of output work: up to WIN_DEPTH bytes, first in lowest byte.
    // A count of zero stands for an empty end-of-string marker.
    typedef struct packed {
        byte_vec_t          bytes;
        logic [COUNT_W-1:0] count;
        logic               fin;
    } job_t;

endpackage

>>> rtl/core/sfr_if.sv
// Valid/ready channel interfaces for input bytes, result beats and configuration writes.
`timescale 1ns / 1ps

interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output byte_valid,
                    output run_last, output string_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input run_last, input string_end, output ready);
endinterface

interface sfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/sfr_front.sv
// Front end: config registers, match window, and classification of each byte into a job.
`timescale 1ns / 1ps

module sfr_front (
    input  logic          clk,
    input  logic          rst_n,
    sfr_in_if.sink        in_ch,
    sfr_cfg_if.sink       cfg,
    input  logic          q_full,
    output logic          job_valid,
    output sfr_pkg::job_t job
);
    import sfr_pkg::*;

    byte_vec_t          pat_bytes_reg;
    logic [COUNT_W-1:0] pat_len_reg;
    byte_vec_t          rep_bytes_reg;
    logic [COUNT_W-1:0] rep_len_reg;
    byte_vec_t          win_reg;
    logic [COUNT_W-1:0] win_count_reg;

    byte_vec_t          win_next;
    logic [COUNT_W-1:0] win_count_next;

    logic [COUNT_W-1:0] plen;
    logic [COUNT_W-1:0] rlen;
    logic [COUNT_W-1:0] cnt_base;
    logic [COUNT_W-1:0] cnt_ins;
    byte_vec_t          win_ins;
    logic               win_full;
    logic               match;
    logic               in_fire;
    logic               fin;

    assign in_ch.ready = !q_full;
    assign cfg.ready   = 1'b1;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign fin         = in_ch.final_byte;

    // Effective lengths
    assign plen = (pat_len_reg > COUNT_W'(PATTERN_MAX)) ? COUNT_W'(PATTERN_MAX) : pat_len_reg;
    assign rlen = (rep_len_reg > COUNT_W'(WIN_DEPTH)) ? COUNT_W'(WIN_DEPTH) : rep_len_reg;

    // Insert the new byte and compare against the pattern
    always_comb
    begin
        cnt_base = (win_count_reg >= plen) ? '0 : win_count_reg;
        win_ins  = win_reg;
        win_ins[cnt_base[WIN_IDX_W-1:0]] = in_ch.data_byte;
        cnt_ins  = cnt_base + COUNT_W'(1);
        win_full = (cnt_ins == plen);
        match    = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            if ((COUNT_W'(i) < plen) && (win_ins[i] != pat_bytes_reg[i]))
                match = 1'b0;
        end
    end

    // Classify: build the job and the next window
    always_comb
    begin
        job.fin        = fin;
        job.bytes      = win_ins;
        job.count      = '0;
        win_next       = win_ins;
        win_count_next = cnt_ins;
        if (plen == '0)
        begin
            job.bytes      = byte_vec_t'(in_ch.data_byte);
            job.count      = COUNT_W'(1);
            win_next       = win_reg;
            win_count_next = '0;
        end
        else if (win_full && match)
        begin
            job.bytes      = rep_bytes_reg;
            job.count      = rlen;
            win_count_next = '0;
        end
        else if (win_full)
        begin
            // oldest byte leaves; on the final byte the whole window drains
            job.count      = fin ? plen : COUNT_W'(1);
            win_next       = {8'h00, win_ins[WIN_DEPTH-1:1]};
            win_count_next = plen - COUNT_W'(1);
        end
        else if (fin)
        begin
            job.count = cnt_ins;
        end
        if (fin)
            win_count_next = '0;
    end

    assign job_valid = in_fire && (fin || (job.count != '0));

    // Config registers and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            win_reg       <= '0;
            win_count_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_PATTERN_BYTES:      pat_bytes_reg <= cfg.data;
                CFG_PATTERN_LENGTH:
                begin
                    pat_len_reg   <= cfg.data[COUNT_W-1:0];
                    win_reg       <= '0;
                    win_count_reg <= '0;
                end
                CFG_REPLACEMENT_BYTES:  rep_bytes_reg <= cfg.data;
                CFG_REPLACEMENT_LENGTH: rep_len_reg   <= cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
        else if (in_fire)
        begin
            win_reg       <= win_next;
            win_count_reg <= win_count_next;
        end
    end

endmodule

>>> rtl/core/sfr_job_queue.sv
// Small FIFO of jobs between the front end and the output sequencer.
`timescale 1ns / 1ps

module sfr_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfr_pkg::job_t push_job,
    output logic          full,
    output logic          head_valid,
    output sfr_pkg::job_t head,
    input  logic          pop
);
    import sfr_pkg::*;

    job_t               q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;
    logic               do_push;
    logic               do_pop;

    assign full       = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= push_job;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

>>> rtl/core/sfr_back.sv
// Back end: walks the head job one byte per beat into the output register.
`timescale 1ns / 1ps

module sfr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  sfr_pkg::job_t head,
    output logic          pop,
    sfr_out_if.source     out_ch
);
    import sfr_pkg::*;

    logic [WIN_IDX_W-1:0] idx_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 byte_valid_reg;
    logic                 run_last_reg;
    logic                 string_end_reg;

    logic                 load;
    logic                 last;

    // Last beat of the current job (a marker job is a single beat)
    assign last = (head.count == '0) ||
                  (COUNT_W'(idx_reg) == (head.count - COUNT_W'(1)));
    assign load = head_valid && (!out_valid_reg || out_ch.ready);
    assign pop  = load && last;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_byte_reg;
    assign out_ch.byte_valid = byte_valid_reg;
    assign out_ch.run_last   = run_last_reg;
    assign out_ch.string_end = string_end_reg;

    // Beat index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= last ? '0 : idx_reg + 1'b1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= (head.count == '0) ? 8'h00 : head.bytes[idx_reg];
            byte_valid_reg <= (head.count != '0);
            run_last_reg   <= last;
            string_end_reg <= last && head.fin;
        end
    end

endmodule

>>> rtl/core/stream_find_and_replace_unit.sv
// Top level of the stream find-and-replace block.
`timescale 1ns / 1ps

// Usage:
//   in_ch  : one string byte per beat, final_byte marks the last byte.
//   out_ch : result beats; run_last closes the results of one input byte,
//            string_end closes the string. An input byte that leaves nothing
//            to emit on the final byte yields one beat with byte_valid low.
//   cfg    : register writes (0 pattern bytes, 1 pattern length, 2 replacement
//            bytes, 3 replacement length); write only while the block is idle.
//            Writing the pattern length drops any held window bytes.
// A byte's first result passes through the job queue and the output
//   register before it is on out_ch. Throughput: one output beat per cycle
//   while the receiver is ready, set by the output sequencer; a byte
//   producing n results yields n beats, one that produces none takes no output
//   beat. Input takes a byte per cycle while the two-entry job queue has room.
// Reset clears the config registers, the window and the queue; out_ch.valid is low.
// When the receiver stalls, the output beat holds, the job queue fills and
//   in_ch.ready drops.
module stream_find_and_replace_unit (
    input  logic      clk,
    input  logic      rst_n,
    sfr_in_if.sink    in_ch,
    sfr_out_if.source out_ch,
    sfr_cfg_if.sink   cfg
);
    import sfr_pkg::*;

    logic job_valid;
    job_t job;
    logic q_full;
    logic head_valid;
    job_t head;
    logic pop;

    sfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .q_full    (q_full),
        .job_valid (job_valid),
        .job       (job)
    );

    sfr_job_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_valid),
        .push_job   (job),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    sfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_ch     (out_ch)
    );

    // The end of a string is always the end of that byte's results
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.string_end |-> out_ch.run_last)
        else $error("string_end without run_last");

    // An empty beat is only the end-of-string marker, with a zero byte
    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.byte_valid |->
            out_ch.string_end && (out_ch.out_byte == 8'h00))
        else $error("empty beat outside end of string");

    // A job never carries more bytes than the window holds
    a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> (job.count <= COUNT_W'(WIN_DEPTH)))
        else $error("job byte count out of range");

    // A byte with no results on a non-final beat pushes no job
    a_no_empty_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job.fin |-> (job.count != '0))
        else $error("empty job pushed for a non-final byte");

endmodule
